FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the averager RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: rtl/core/wgpa_pkg.sv
// Shared types and constants of the warm-up gated particulate averager.
// Depends on nothing; used by wgpa_lane and warmup_gated_pm_averager.
`default_nettype none

package wgpa_pkg;

  // Ring depth and derived widths.
  localparam int BUF_DEPTH  = 32;
  localparam int PTR_W      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = $clog2(BUF_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DIV_CNT_W  = (SUM_W > 1) ? $clog2(SUM_W) : 1;
  localparam int NUM_LANES  = 3;

  // Field widths of the stream items.
  localparam int REQ_W      = 2;
  localparam int TIME_W     = 32;
  localparam int WARMUP_W   = 16;
  localparam int USED_W     = 6;
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 56;

  // One day in seconds.
  localparam logic [TIME_W-1:0] ONE_DAY_SECONDS = TIME_W'(3600 * 24);

  // Request kinds carried in tuser.
  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 2'd0,
    REQ_SAMPLE  = 2'd1,
    REQ_AVERAGE = 2'd2
  } req_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DIV,
    ST_DONE
  } state_t;

  // Commands broadcast from the sequencer to every lane.
  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic             wr_en;
    logic             sub_old;
    logic [PTR_W-1:0] addr;
    logic             div_load;
    logic             div_step;
    logic [CNT_W-1:0] divisor;
  } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/wgpa_lane.sv
// One channel lane: ring column, running sum and a bit-serial restoring divider.
// Depends on wgpa_pkg for widths and the lane command struct.
`default_nettype none

module wgpa_lane (
  input  wire                             clk,
  input  wire                             rst,
  input  wire  wgpa_pkg::lane_ctrl_t      ctrl,
  input  wire  [wgpa_pkg::SAMPLE_W-1:0]   sample,
  output logic [wgpa_pkg::SAMPLE_W-1:0]   quotient
);

  logic [wgpa_pkg::SAMPLE_W-1:0] ring [wgpa_pkg::BUF_DEPTH];
  logic [wgpa_pkg::SAMPLE_W-1:0] rd_data;
  logic [wgpa_pkg::SUM_W-1:0]    sum;
  logic [wgpa_pkg::SUM_W-1:0]    old_val;
  logic [wgpa_pkg::SUM_W-1:0]    quot;
  logic [wgpa_pkg::CNT_W-1:0]    rem;
  logic [wgpa_pkg::CNT_W:0]      trial;
  logic                          fits;

  // Ring column with a registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      ring[ctrl.addr] <= sample;
    end
    if (ctrl.rd_en) begin
      rd_data <= ring[ctrl.addr];
    end
  end

  // The entry being overwritten leaves the sum only once the ring is full.
  assign old_val = ctrl.sub_old ? wgpa_pkg::SUM_W'(rd_data) : '0;

  // Running sum of the stored readings.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.wr_en) begin
      sum <= sum - old_val + wgpa_pkg::SUM_W'(sample);
    end
  end

  // One quotient bit per cycle, most significant dividend bit first.
  assign trial = {rem, quot[wgpa_pkg::SUM_W-1]};
  assign fits  = (trial >= {1'b0, ctrl.divisor});

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      quot <= sum;
      rem  <= '0;
    end else if (ctrl.div_step) begin
      quot <= {quot[wgpa_pkg::SUM_W-2:0], fits};
      rem  <= fits ? wgpa_pkg::CNT_W'(trial - {1'b0, ctrl.divisor})
                   : trial[wgpa_pkg::CNT_W-1:0];
    end
  end

  // A mean never exceeds one reading, so the low bits hold it whole.
  assign quotient = quot[wgpa_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/warmup_gated_pm_averager.sv
// Top level of the warm-up gated particulate averager: sequencer, three lanes, merge.
// Depends on wgpa_pkg, wgpa_lane and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Accepts start, sample and average requests on the slave stream and returns
// one result per average request on the master stream. A start request, a
// request with an unused kind or a dropped sample leaves the block ready; a kept
// sample passes through a ring read, then the sum update and write, before
// ready returns. For an average request with samples stored, the
// three lane dividers run side by side and produce one quotient bit per cycle
// over the 21-bit sums, then the merge stage loads the output register. With
// the store empty the zero result goes straight to the merge stage. A finished result
// waits in the output register while the next request is already taken; only
// a second average request stalls behind a result that has not been taken.
// The warm-up register may be written whenever no request is in progress.
module warmup_gated_pm_averager (
  input  wire                               clk,
  input  wire                               rst,
  // Warm-up register write.
  input  wire                               cfg_we,
  input  wire  [wgpa_pkg::WARMUP_W-1:0]     cfg_wdata,
  // Request stream.
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: pm1_0_value[15:0], pm2_5_value[31:16], pm10_value[47:32],
  //        now_seconds[79:48]
  input  wire  [wgpa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire  [wgpa_pkg::REQ_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata: avg_pm1_0[15:0], avg_pm2_5[31:16], avg_pm10[47:32],
  //        samples_used[53:48], zero padding[55:54]
  output logic [wgpa_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  wgpa_pkg::state_t               state;
  wgpa_pkg::state_t               state_next;
  wgpa_pkg::req_t                 req;
  wgpa_pkg::lane_ctrl_t           ctrl;

  logic [wgpa_pkg::WARMUP_W-1:0]  warmup;
  logic [wgpa_pkg::TIME_W-1:0]    start_time;
  logic [wgpa_pkg::PTR_W-1:0]     wr_ptr;
  logic [wgpa_pkg::CNT_W-1:0]     stored_count;
  logic [wgpa_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [wgpa_pkg::SAMPLE_W-1:0]  smp [wgpa_pkg::NUM_LANES];
  logic [wgpa_pkg::SAMPLE_W-1:0]  quot [wgpa_pkg::NUM_LANES];
  logic [wgpa_pkg::SAMPLE_W-1:0]  out_avg [wgpa_pkg::NUM_LANES];
  logic [wgpa_pkg::USED_W-1:0]    out_used;

  logic [wgpa_pkg::TIME_W-1:0]    now;
  logic [wgpa_pkg::TIME_W-1:0]    elapsed;
  logic                           s_accept;
  logic                           over_day;
  logic                           keep;
  logic                           full;
  logic                           empty;
  logic                           out_free;
  logic                           div_last;

  // Request decode.
  assign req      = wgpa_pkg::req_t'(s_axis_tuser);
  assign now      = s_axis_tdata[79:48];
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Elapsed time since start, read as a signed difference.
  assign elapsed  = now - start_time;
  assign over_day = !elapsed[wgpa_pkg::TIME_W-1] && (elapsed > wgpa_pkg::ONE_DAY_SECONDS);
  assign keep     = !elapsed[wgpa_pkg::TIME_W-1] && !over_day &&
                    (elapsed > wgpa_pkg::TIME_W'(warmup));

  assign full     = (stored_count == wgpa_pkg::CNT_W'(wgpa_pkg::BUF_DEPTH));
  assign empty    = (stored_count == '0);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign div_last = (div_cnt == wgpa_pkg::DIV_CNT_W'(wgpa_pkg::SUM_W - 1));

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wgpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      wgpa_pkg::ST_IDLE: begin
        if (s_accept) begin
          case (req)
            wgpa_pkg::REQ_SAMPLE: begin
              if (keep) state_next = wgpa_pkg::ST_READ;
            end
            wgpa_pkg::REQ_AVERAGE: begin
              state_next = empty ? wgpa_pkg::ST_DONE : wgpa_pkg::ST_DIV;
            end
            default: state_next = wgpa_pkg::ST_IDLE;
          endcase
        end
      end
      wgpa_pkg::ST_READ:  state_next = wgpa_pkg::ST_WRITE;
      wgpa_pkg::ST_WRITE: state_next = wgpa_pkg::ST_IDLE;
      wgpa_pkg::ST_DIV: begin
        if (div_last) state_next = wgpa_pkg::ST_DONE;
      end
      wgpa_pkg::ST_DONE: begin
        if (out_free) state_next = wgpa_pkg::ST_IDLE;
      end
      default: state_next = wgpa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: ready and the lane commands.
  always_comb begin
    s_axis_tready = (state == wgpa_pkg::ST_IDLE);
    ctrl.clear    = s_accept && (req == wgpa_pkg::REQ_START);
    ctrl.rd_en    = (state == wgpa_pkg::ST_READ);
    ctrl.wr_en    = (state == wgpa_pkg::ST_WRITE);
    ctrl.sub_old  = full;
    ctrl.addr     = wr_ptr;
    ctrl.div_load = s_accept && (req == wgpa_pkg::REQ_AVERAGE);
    ctrl.div_step = (state == wgpa_pkg::ST_DIV);
    ctrl.divisor  = stored_count;
  end

  // Warm-up register.
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup <= '0;
    end else if (cfg_we) begin
      warmup <= cfg_wdata;
    end
  end

  // Start time: set by a start request, or re-armed after more than a day.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
    end else if (s_accept && (req == wgpa_pkg::REQ_START)) begin
      start_time <= now;
    end else if (s_accept && (req == wgpa_pkg::REQ_SAMPLE) && over_day) begin
      start_time <= now;
    end
  end

  // Write pointer and saturating fill count.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      wr_ptr       <= '0;
      stored_count <= '0;
    end else if (ctrl.wr_en) begin
      wr_ptr <= (wr_ptr == wgpa_pkg::PTR_W'(wgpa_pkg::BUF_DEPTH - 1)) ? '0
                                                                      : wr_ptr + 1'b1;
      if (!full) stored_count <= stored_count + 1'b1;
    end
  end

  // Readings of the request, held for the ring write.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      smp[0] <= s_axis_tdata[15:0];
      smp[1] <= s_axis_tdata[31:16];
      smp[2] <= s_axis_tdata[47:32];
    end
  end

  // Divider step counter.
  always_ff @(posedge clk) begin
    if (rst || (state != wgpa_pkg::ST_DIV)) begin
      div_cnt <= '0;
    end else begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // One lane per particulate channel.
  for (genvar g = 0; g < wgpa_pkg::NUM_LANES; g++) begin : g_lane
    wgpa_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sample   (smp[g]),
      .quotient (quot[g])
    );
  end

  // Merge stage: gather the lane quotients into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == wgpa_pkg::ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == wgpa_pkg::ST_DONE) && out_free) begin
      for (int i = 0; i < wgpa_pkg::NUM_LANES; i++) begin
        out_avg[i] <= empty ? '0 : quot[i];
      end
      out_used <= wgpa_pkg::USED_W'(stored_count);
    end
  end

  assign m_axis_tdata = {2'b00, out_used, out_avg[2], out_avg[1], out_avg[0]};

  // Checks on the sequencer and the fill bookkeeping.
  `ASSERT_ALWAYS(a_count_max, clk, rst, stored_count <= wgpa_pkg::CNT_W'(wgpa_pkg::BUF_DEPTH))
  `ASSERT_IMPL(a_ptr_tracks_count, clk, rst, !full, wr_ptr == wgpa_pkg::PTR_W'(stored_count))
  `ASSERT_IMPL(a_write_after_read, clk, rst, state == wgpa_pkg::ST_WRITE, $past(state) == wgpa_pkg::ST_READ)
  `ASSERT_NEXT(a_avg_starts_div, clk, rst, s_accept && (req == wgpa_pkg::REQ_AVERAGE) && !empty, state == wgpa_pkg::ST_DIV)

endmodule

`default_nettype wire

FILE: sim/tb_warmup_gated_pm_averager.sv
// Testbench of warmup_gated_pm_averager: a directed table of requests, then random phases.
// Depends on wgpa_pkg and the averager RTL; results are checked against a local predictor or typed table rows.
module tb_warmup_gated_pm_averager;
  import wgpa_pkg::*;

  // Request code with no meaning; the block must ignore it.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 265;
  localparam int NUM_PHASES   = 6;
  localparam int CALM_PHASE   = 2;
  localparam int HOLD_PHASE   = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PERCENT = 29;
  localparam int DIRECTED_N   = 23;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pm1_0;
    logic [SAMPLE_W-1:0] pm2_5;
    logic [SAMPLE_W-1:0] pm10;
    logic [USED_W-1:0]   used;
  } avg_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]    kind;
    logic [SAMPLE_W-1:0] pm1_0;
    logic [SAMPLE_W-1:0] pm2_5;
    logic [SAMPLE_W-1:0] pm10;
    logic [TIME_W-1:0]   now;
    logic                typed;
    avg_result_t         typed_result;
  } directed_row_t;

  // Opening sequence with warm-up at zero. Rows marked typed carry their result.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1, '{16'h0, 16'h0, 16'h0, 6'd0}},
    '{REQ_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd100, 1'b0, '0},
    '{REQ_SAMPLE, 16'h7, 16'h7, 16'h7, 32'd100, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1, '{16'h0, 16'h0, 16'h0, 6'd0}},
    '{REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd101, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd1}},
    '{REQ_SAMPLE, 16'h0, 16'h0, 16'h0, 32'd102, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1,
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 6'd2}},
    '{REQ_SAMPLE, 16'h1, 16'h1, 16'h1, 32'd99, 1'b0, '0},
    '{REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1,
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 6'd2}},
    '{REQ_SAMPLE, 16'h5, 16'h5, 16'h5, 32'd86501, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1,
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 6'd2}},
    '{REQ_SAMPLE, 16'h1, 16'h2, 16'h3, 32'd86502, 1'b0, '0},
    '{REQ_SAMPLE, 16'hAAAA, 16'h5555, 16'hFFFF, 32'd172901, 1'b0, '0},
    '{REQ_AVERAGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_START, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1, '{16'h0, 16'h0, 16'h0, 6'd0}},
    '{REQ_SAMPLE, 16'h1234, 16'h5678, 16'h9ABC, 32'd0, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 6'd1}},
    '{REQ_SAMPLE, 16'h1, 16'h1, 16'h1, 32'h8000_0000, 1'b0, '0},
    '{REQ_SAMPLE, 16'h2, 16'h2, 16'h2, 32'd86401, 1'b0, '0},
    '{REQ_AVERAGE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1,
      '{16'h1234, 16'h5678, 16'h9ABC, 6'd1}}
  };

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [WARMUP_W-1:0]   cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // tdata: pm1_0_value, pm2_5_value, pm10_value, now_seconds (lowest bit up)
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser: req_type
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // tdata: avg_pm1_0, avg_pm2_5, avg_pm10, samples_used, zero padding
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  // Predictor state of the averager.
  logic [3*SAMPLE_W-1:0] ring_entries [BUF_DEPTH];
  int                    ring_wr_ptr = 0;
  int                    ring_fill = 0;
  logic [TIME_W-1:0]     window_start = '0;
  logic [SUM_W-1:0]      channel_total [NUM_LANES];
  logic [WARMUP_W-1:0]   warmup_limit = '0;

  avg_result_t           mean_expect_q [$];
  avg_result_t           observed;
  avg_result_t           awaited;
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  logic                  calm_phase = 1'b0;
  logic                  hold_request = 1'b0;

  warmup_gated_pm_averager u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int c = 0; c < NUM_LANES; c++) begin
      channel_total[c] = '0;
    end
  end

  // Applies one request to the predictor; returns 1 when it yields an average.
  function automatic bit predict_means(input logic [REQ_W-1:0] kind,
                                       input logic [S_TDATA_W-1:0] data,
                                       output avg_result_t res);
    int               elapsed;
    int               c;
    logic [TIME_W-1:0] now;
    logic [SUM_W-1:0] quotient;
    logic [SAMPLE_W-1:0] mean [NUM_LANES];
    now = data[S_TDATA_W-1 -: TIME_W];
    res = '0;
    predict_means = 1'b0;
    case (kind)
      REQ_START: begin
        ring_fill = 0;
        ring_wr_ptr = 0;
        for (c = 0; c < NUM_LANES; c++) begin
          channel_total[c] = '0;
        end
        window_start = now;
      end
      REQ_SAMPLE: begin
        elapsed = int'(now - window_start);
        // More than a day since start restarts the window at this sample.
        if (elapsed > int'(ONE_DAY_SECONDS)) begin
          window_start = now;
          elapsed = 0;
        end
        if (elapsed > int'(warmup_limit)) begin
          for (c = 0; c < NUM_LANES; c++) begin
            if (ring_fill >= BUF_DEPTH) begin
              channel_total[c] -= SUM_W'(ring_entries[ring_wr_ptr][SAMPLE_W*c +: SAMPLE_W]);
            end
            channel_total[c] += SUM_W'(data[SAMPLE_W*c +: SAMPLE_W]);
          end
          ring_entries[ring_wr_ptr] = data[3*SAMPLE_W-1:0];
          ring_wr_ptr = (ring_wr_ptr + 1) % BUF_DEPTH;
          if (ring_fill < BUF_DEPTH) begin
            ring_fill++;
          end
        end
      end
      REQ_AVERAGE: begin
        for (c = 0; c < NUM_LANES; c++) begin
          quotient = '0;
          if (ring_fill != 0) begin
            quotient = channel_total[c] / SUM_W'(ring_fill);
          end
          mean[c] = quotient[SAMPLE_W-1:0];
        end
        res = '{mean[0], mean[1], mean[2], USED_W'(ring_fill)};
        predict_means = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Time offset from the window start, mostly inside the keep window.
  function automatic logic [TIME_W-1:0] pick_offset();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) begin
      return $urandom_range(int'(ONE_DAY_SECONDS), int'(warmup_limit) + 1);
    end else if (sel < 88) begin
      return $urandom_range(int'(warmup_limit), 0);
    end else if (sel < 92) begin
      return $urandom;
    end else if (sel < 96) begin
      case ($urandom_range(3))
        0: return TIME_W'(warmup_limit);
        1: return TIME_W'(warmup_limit) + 1;
        2: return ONE_DAY_SECONDS;
        default: return ONE_DAY_SECONDS + 1;
      endcase
    end
    return TIME_W'(0) - TIME_W'($urandom_range(1000, 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_reading();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offers one request, with random gaps, and returns once it is taken.
  task automatic offer_request(input logic [REQ_W-1:0] kind,
                               input logic [S_TDATA_W-1:0] data);
    @(negedge clk);
    while (!calm_phase && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Offers a request and records the average it should produce.
  task automatic issue_request(input logic [REQ_W-1:0] kind,
                               input logic [S_TDATA_W-1:0] data,
                               input logic typed,
                               input avg_result_t typed_result);
    avg_result_t predicted;
    offer_request(kind, data);
    if (predict_means(kind, data, predicted)) begin
      mean_expect_q.push_back(typed ? typed_result : predicted);
    end
  endtask

  // Writes the warm-up register once the block has gone quiet.
  task automatic write_warmup(input logic [WARMUP_W-1:0] value);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (mean_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    warmup_limit = value;
  endtask

  function automatic void check_field(input string name, input logic [SAMPLE_W-1:0] want,
                                      input logic [SAMPLE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_axis_tready <= calm_phase || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Compare each taken result with the oldest expected average.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      observed = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tdata[53:48]};
      if (mean_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        awaited = mean_expect_q.pop_front();
        check_field("avg_pm1_0", awaited.pm1_0, observed.pm1_0);
        check_field("avg_pm2_5", awaited.pm2_5, observed.pm2_5);
        check_field("avg_pm10", awaited.pm10, observed.pm10);
        check_field("samples_used", SAMPLE_W'(awaited.used), SAMPLE_W'(observed.used));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d averages outstanding", $time, mean_expect_q.size());
    $display("status: fail");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases of warm-up settings.
  initial begin
    logic [REQ_W-1:0]     kind;
    logic [TIME_W-1:0]    now;
    logic [WARMUP_W-1:0]  warmup_value;
    int                   pick;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    write_warmup('0);

    for (int i = 0; i < DIRECTED_N; i++) begin
      issue_request(DIRECTED_ROWS[i].kind,
                    {DIRECTED_ROWS[i].now, DIRECTED_ROWS[i].pm10,
                     DIRECTED_ROWS[i].pm2_5, DIRECTED_ROWS[i].pm1_0},
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_result);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: warmup_value = '1;
        1: warmup_value = '0;
        3: warmup_value = 16'd1;
        default: warmup_value = WARMUP_W'($urandom);
      endcase
      write_warmup(warmup_value);
      calm_phase = (p == CALM_PHASE);
      if (p == HOLD_PHASE) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        now = $urandom;
        if (pick < 2) begin
          kind = REQ_START;
        end else if (pick < 5) begin
          kind = REQ_UNUSED;
        end else if (pick < 25) begin
          kind = REQ_AVERAGE;
        end else begin
          kind = REQ_SAMPLE;
          now = window_start + pick_offset();
        end
        issue_request(kind, {now, pick_reading(), pick_reading(), pick_reading()},
                      1'b0, '0);
      end
    end
    calm_phase = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (mean_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
